// ===== src/particle_force_velocity_update_assert.svh =====
// Assertion macros for the particle force block.
`ifndef PARTICLE_FORCE_VELOCITY_UPDATE_ASSERT_SVH
`define PARTICLE_FORCE_VELOCITY_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define PFVU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pfvu check failed");
`define PFVU_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pfvu check failed");
`else
`define PFVU_ASSERT(label, clk, rst, prop)
`define PFVU_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== src/pfvu_pkg.sv =====
`default_nettype none
package pfvu_pkg;

   localparam int unsigned NUM_STAGES  = 58;
   localparam int unsigned ST_DIFF     = 0;
   localparam int unsigned ST_ABS      = 1;
   localparam int unsigned ST_MAX      = 2;
   localparam int unsigned ST_MSB      = 3;
   localparam int unsigned ST_SCALE    = 4;
   localparam int unsigned ST_SQUARE   = 5;
   localparam int unsigned ST_SUM      = 6;
   localparam int unsigned ST_SQRT     = 7;
   localparam int unsigned ST_DIV      = 38;
   localparam int unsigned ST_SIGN     = 55;
   localparam int unsigned ST_PROD     = 56;
   localparam int unsigned ST_OUT      = 57;

   typedef enum logic [2:0] {
      CSR_FORCE_MODE   = 3'd0,
      CSR_FORCE_AMOUNT = 3'd1,
      CSR_WIND_DIR_X   = 3'd2,
      CSR_WIND_DIR_Y   = 3'd3,
      CSR_WIND_DIR_Z   = 3'd4,
      CSR_CENTER_X     = 3'd5,
      CSR_CENTER_Y     = 3'd6,
      CSR_CENTER_Z     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic             mode;
      logic [31:0]      amount;
      logic [2:0][31:0] wind;
      logic [2:0][31:0] center;
   } cfg_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [23:0]      t;
      logic [2:0][31:0] vel;
      logic [55:0]      ftp;
      logic [31:0]      ft;
      logic [2:0][32:0] d;
      logic [2:0]       neg;
      logic [32:0]      mx;
      logic [5:0]       msb;
      logic             zero;
      logic [2:0][63:0] wp;
      logic [2:0][47:0] wt;
      logic [2:0][29:0] sa;
      logic [2:0][59:0] sq;
      logic [61:0]      rad;
      logic [33:0]      rem;
      logic [30:0]      root;
      logic [2:0][31:0] r;
      logic [2:0][16:0] q;
      logic [2:0][17:0] u;
      logic [2:0][49:0] pp;
   } item_type;

   function automatic logic [31:0] sat32(input logic signed [48:0] v);
      logic [31:0] res;
      if (v > 49'sd2147483647) begin
         res = 32'h7fff_ffff;
      end else if (v < -49'sd2147483648) begin
         res = 32'h8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   function automatic item_type stage_next(input int unsigned k, input item_type x,
                                           input cfg_type c);
      item_type          y;
      logic signed [56:0] fp;
      logic signed [39:0] fs;
      logic signed [63:0] wpm;
      logic signed [49:0] pm;
      logic signed [48:0] term;
      logic signed [48:0] sum;
      logic [33:0]        rem2;
      logic [33:0]        trial;
      logic [31:0]        rin;
      logic [5:0]         sh;
      y = x;
      if (k == ST_DIFF) begin
         for (int i = 0; i < 3; i++) begin
            y.d[i] = 33'($signed(x.pos[i])) - 33'($signed(c.center[i]));
         end
         fp = $signed(c.amount) * $signed({1'b0, x.t});
         y.ftp = fp[55:0];
      end else if (k == ST_ABS) begin
         fs = 40'($signed(x.ftp) >>> 16);
         y.ft = sat32(49'(fs));
         for (int i = 0; i < 3; i++) begin
            y.neg[i] = x.d[i][32];
            y.d[i] = x.d[i][32] ? 33'(-x.d[i]) : x.d[i];
         end
      end else if (k == ST_MAX) begin
         y.mx = x.d[0];
         if (x.d[1] > y.mx) begin
            y.mx = x.d[1];
         end
         if (x.d[2] > y.mx) begin
            y.mx = x.d[2];
         end
         for (int i = 0; i < 3; i++) begin
            wpm = $signed(x.ft) * $signed(c.wind[i]);
            y.wp[i] = wpm;
         end
      end else if (k == ST_MSB) begin
         y.msb = '0;
         for (int b = 0; b < 33; b++) begin
            if (x.mx[b]) begin
               y.msb = 6'(b);
            end
         end
         y.zero = (x.mx == '0);
         for (int i = 0; i < 3; i++) begin
            y.wt[i] = 48'($signed(x.wp[i]) >>> 16);
         end
      end else if (k == ST_SCALE) begin
         for (int i = 0; i < 3; i++) begin
            if (x.msb >= 6'd30) begin
               sh = x.msb - 6'd29;
               y.sa[i] = 30'(x.d[i] >> sh);
            end else begin
               sh = 6'd29 - x.msb;
               y.sa[i] = 30'(x.d[i] << sh);
            end
         end
      end else if (k == ST_SQUARE) begin
         for (int i = 0; i < 3; i++) begin
            y.sq[i] = 60'(x.sa[i]) * 60'(x.sa[i]);
         end
      end else if (k == ST_SUM) begin
         y.rad  = 62'(x.sq[0]) + 62'(x.sq[1]) + 62'(x.sq[2]);
         y.rem  = '0;
         y.root = '0;
      end else if (k < ST_DIV) begin
         rem2  = {x.rem[31:0], x.rad[61:60]};
         trial = {1'b0, x.root, 2'b01};
         y.rad = {x.rad[59:0], 2'b00};
         if (rem2 >= trial) begin
            y.rem  = rem2 - trial;
            y.root = {x.root[29:0], 1'b1};
         end else begin
            y.rem  = rem2;
            y.root = {x.root[29:0], 1'b0};
         end
      end else if (k < ST_SIGN) begin
         for (int i = 0; i < 3; i++) begin
            rin = (k == ST_DIV) ? {2'b00, x.sa[i]} : {x.r[i][30:0], 1'b0};
            if (rin >= {1'b0, x.root}) begin
               y.r[i] = rin - {1'b0, x.root};
               y.q[i] = {x.q[i][15:0], 1'b1};
            end else begin
               y.r[i] = rin;
               y.q[i] = {x.q[i][15:0], 1'b0};
            end
         end
      end else if (k == ST_SIGN) begin
         for (int i = 0; i < 3; i++) begin
            if (x.zero) begin
               y.u[i] = '0;
            end else if (x.neg[i]) begin
               y.u[i] = 18'(-{1'b0, x.q[i]});
            end else begin
               y.u[i] = {1'b0, x.q[i]};
            end
         end
      end else if (k == ST_PROD) begin
         for (int i = 0; i < 3; i++) begin
            pm = $signed(x.ft) * $signed(x.u[i]);
            y.pp[i] = pm;
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            term = c.mode ? 49'($signed(x.pp[i]) >>> 16) : 49'($signed(x.wt[i]));
            sum = term + 49'($signed(x.vel[i]));
            y.vel[i] = sat32(sum);
         end
      end
      return y;
   endfunction

endpackage
`default_nettype wire

// ===== src/pfvu_slot.sv =====
`default_nettype none
module pfvu_slot (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire pfvu_pkg::item_type in_data,
   input  wire logic              down_ready,
   output logic                   ready,
   output logic                   out_valid,
   output pfvu_pkg::item_type     out_data
);

   logic               valid_ff;
   logic               valid_in;
   pfvu_pkg::item_type data_ff;
   pfvu_pkg::item_type data_in;

   always_comb begin
      ready    = !valid_ff || down_ready;
      valid_in = ready ? in_valid : valid_ff;
      data_in  = ready ? in_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== src/particle_force_velocity_update.sv =====
// Particle force velocity update.
// Request channel: req_valid with req_pos_*, req_vel_* and req_time_step; the
// block holds req_stall high when it cannot take an item. Response channel:
// rsp_valid with rsp_new_vel_*; the receiver holds rsp_stall high to refuse.
// The user writes settings through csr_we / csr_index / csr_data only while
// idle; the block does not enforce this. An item passes through one stage
// each for offset, force scale, max search, leading-one search, normalize
// shift, squares and their sum, 31 stages of the one-bit-per-stage square
// root and 17 stages of the three one-bit-per-stage dividers, then sign, force
// product and saturating add. One item enters every cycle while not stalled.
// Reset clears all settings to zero and empties every pipeline slot.
// While rsp_stall is high, occupied slots hold; empty slots ahead of them keep
// filling, so req_stall rises only once the first slot holds a stuck item.
`default_nettype none
`include "particle_force_velocity_update_assert.svh"
module particle_force_velocity_update (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_vel_x,
   input  wire logic [31:0] req_vel_y,
   input  wire logic [31:0] req_vel_z,
   input  wire logic [23:0] req_time_step,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_new_vel_x,
   output logic [31:0]      rsp_new_vel_y,
   output logic [31:0]      rsp_new_vel_z,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   pfvu_pkg::cfg_type  cfg_ff;
   pfvu_pkg::cfg_type  cfg_in;
   pfvu_pkg::item_type entry;
   pfvu_pkg::item_type stage_d [pfvu_pkg::NUM_STAGES];
   pfvu_pkg::item_type stage_q [pfvu_pkg::NUM_STAGES];
   logic [pfvu_pkg::NUM_STAGES-1:0] slot_valid;
   logic [pfvu_pkg::NUM_STAGES:0]   ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            pfvu_pkg::CSR_FORCE_MODE:   cfg_in.mode      = csr_data[0];
            pfvu_pkg::CSR_FORCE_AMOUNT: cfg_in.amount    = csr_data;
            pfvu_pkg::CSR_WIND_DIR_X:   cfg_in.wind[0]   = csr_data;
            pfvu_pkg::CSR_WIND_DIR_Y:   cfg_in.wind[1]   = csr_data;
            pfvu_pkg::CSR_WIND_DIR_Z:   cfg_in.wind[2]   = csr_data;
            pfvu_pkg::CSR_CENTER_X:     cfg_in.center[0] = csr_data;
            pfvu_pkg::CSR_CENTER_Y:     cfg_in.center[1] = csr_data;
            pfvu_pkg::CSR_CENTER_Z:     cfg_in.center[2] = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      entry        = '0;
      entry.pos[0] = req_pos_x;
      entry.pos[1] = req_pos_y;
      entry.pos[2] = req_pos_z;
      entry.vel[0] = req_vel_x;
      entry.vel[1] = req_vel_y;
      entry.vel[2] = req_vel_z;
      entry.t      = req_time_step;
   end

   assign ready[pfvu_pkg::NUM_STAGES] = !rsp_stall;

   for (genvar k = 0; k < pfvu_pkg::NUM_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign stage_d[k] = pfvu_pkg::stage_next(32'(k), entry, cfg_ff);
         pfvu_slot u_slot (
            .clock      (clock),
            .reset      (reset),
            .in_valid   (req_valid),
            .in_data    (stage_d[k]),
            .down_ready (ready[k+1]),
            .ready      (ready[k]),
            .out_valid  (slot_valid[k]),
            .out_data   (stage_q[k])
         );
      end else begin : g_rest
         assign stage_d[k] = pfvu_pkg::stage_next(32'(k), stage_q[k-1], cfg_ff);
         pfvu_slot u_slot (
            .clock      (clock),
            .reset      (reset),
            .in_valid   (slot_valid[k-1]),
            .in_data    (stage_d[k]),
            .down_ready (ready[k+1]),
            .ready      (ready[k]),
            .out_valid  (slot_valid[k]),
            .out_data   (stage_q[k])
         );
      end
   end

   assign req_stall     = !ready[0];
   assign rsp_valid     = slot_valid[pfvu_pkg::NUM_STAGES-1];
   assign rsp_new_vel_x = stage_q[pfvu_pkg::NUM_STAGES-1].vel[0];
   assign rsp_new_vel_y = stage_q[pfvu_pkg::NUM_STAGES-1].vel[1];
   assign rsp_new_vel_z = stage_q[pfvu_pkg::NUM_STAGES-1].vel[2];

   `PFVU_ASSERT_ALWAYS(a_free_out_free_in, clock, !rsp_stall |-> !req_stall)
   `PFVU_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid)
   `PFVU_ASSERT(a_accept_fills, clock, reset, req_valid && !req_stall |=> slot_valid[0])

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

   typedef struct {
      logic [31:0] pos [3];
      logic [31:0] vel [3];
      logic [23:0] t;
   } particle_type;

   typedef struct {
      logic [31:0] v [3];
   } velocity_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [31:0] req_vel_x = '0, req_vel_y = '0, req_vel_z = '0;
   logic [23:0] req_time_step = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   particle_type pending [$];
   velocity_type expected_vel [$];
   int          errors = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   bit          throttle = 1'b1;

   logic               sh_mode = 1'b0;
   logic signed [31:0] sh_amount = '0;
   logic signed [31:0] sh_wind [3] = '{default: '0};
   logic signed [31:0] sh_center [3] = '{default: '0};

   particle_force_velocity_update dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!throttle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic velocity_type update_velocity(particle_type p);
      velocity_type    res;
      longint          ft;
      longint          term [3];
      longint          d [3];
      longint unsigned a [3];
      longint unsigned m;
      longint unsigned len;
      longint          q;
      ft = clamp32((longint'(sh_amount) * longint'({40'd0, p.t})) >>> 16);
      m = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'($signed(p.pos[i])) - longint'(sh_center[i]);
         a[i] = d[i] < 0 ? -d[i] : d[i];
         if (a[i] > m) m = a[i];
      end
      if (!sh_mode) begin
         for (int i = 0; i < 3; i++) term[i] = (ft * longint'(sh_wind[i])) >>> 16;
      end else if (m == 0) begin
         for (int i = 0; i < 3; i++) term[i] = 0;
      end else begin
         while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) a[i] >>= 1;
            m >>= 1;
         end
         while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) a[i] <<= 1;
            m <<= 1;
         end
         len = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
         for (int i = 0; i < 3; i++) begin
            q = longint'((a[i] << 16) / len);
            if (d[i] < 0) q = -q;
            term[i] = (ft * q) >>> 16;
         end
      end
      for (int i = 0; i < 3; i++)
         res.v[i] = 32'(clamp32(longint'($signed(p.vel[i])) + term[i]));
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending.size() > 0) begin
            particle_type p;
            p = pending.pop_front();
            req_valid <= 1'b1;
            {req_pos_x, req_pos_y, req_pos_z} <= {p.pos[0], p.pos[1], p.pos[2]};
            {req_vel_x, req_vel_y, req_vel_z} <= {p.vel[0], p.vel[1], p.vel[2]};
            req_time_step <= p.t;
            req_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         rsp_gap <= pick_gap();
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            particle_type p;
            p.pos = '{req_pos_x, req_pos_y, req_pos_z};
            p.vel = '{req_vel_x, req_vel_y, req_vel_z};
            p.t = req_time_step;
            expected_vel.insert(expected_vel.size(), update_velocity(p));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_vel.size() == 0) begin
               $error("unexpected velocity item %h %h %h",
                      rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z);
               errors++;
            end else begin
               velocity_type e;
               logic [31:0] got [3];
               e = expected_vel.pop_front();
               got = '{rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z};
               for (int i = 0; i < 3; i++) begin
                  if (got[i] !== e.v[i]) begin
                     $error("new_vel_%s expected %h actual %h",
                            i == 0 ? "x" : i == 1 ? "y" : "z", e.v[i], got[i]);
                     errors++;
                  end
               end
            end
         end
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return 32'($signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [23:0] pick_time();
      case ($urandom_range(0, 9))
         0: return 24'h0;
         1: return 24'hff_ffff;
         2, 3: return 24'($urandom);
         default: return 24'($urandom_range(0, 32'h0002_0000));
      endcase
   endfunction

   task automatic push_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                logic [23:0] t);
      particle_type p;
      p.pos = '{px, py, pz};
      p.vel = '{vx, vy, vz};
      p.t = t;
      pending.insert(pending.size(), p);
   endtask

   task automatic push_random(int n);
      logic [31:0] pos [3];
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 5))
               0: pos[i] = sh_center[i];
               1, 2: pos[i] = sh_center[i] + 32'($signed($urandom_range(0, 4096)) - 2048);
               default: pos[i] = pick_word();
            endcase
         end
         push_particle(pos[0], pos[1], pos[2], pick_word(), pick_word(), pick_word(),
                       pick_time());
      end
   endtask

   task automatic write_reg(pfvu_pkg::csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(logic mode, logic [31:0] amount, logic [31:0] w0,
                            logic [31:0] w1, logic [31:0] w2, logic [31:0] c0,
                            logic [31:0] c1, logic [31:0] c2);
      do @(posedge clock);
      while (pending.size() != 0 || req_valid || expected_vel.size() != 0);
      repeat (70) @(posedge clock);
      write_reg(pfvu_pkg::CSR_FORCE_MODE, {31'd0, mode});
      write_reg(pfvu_pkg::CSR_FORCE_AMOUNT, amount);
      write_reg(pfvu_pkg::CSR_WIND_DIR_X, w0);
      write_reg(pfvu_pkg::CSR_WIND_DIR_Y, w1);
      write_reg(pfvu_pkg::CSR_WIND_DIR_Z, w2);
      write_reg(pfvu_pkg::CSR_CENTER_X, c0);
      write_reg(pfvu_pkg::CSR_CENTER_Y, c1);
      write_reg(pfvu_pkg::CSR_CENTER_Z, c2);
      sh_mode = mode;
      sh_amount = amount;
      sh_wind = '{w0, w1, w2};
      sh_center = '{c0, c1, c2};
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // reset settings: zero force
      push_particle(32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff, 32'h8000_0000, 1,
                    24'hff_ffff);
      push_random(20);

      configure(1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                0, 0, 0);
      push_particle(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 24'hff_ffff);
      push_particle(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 24'h0);
      push_particle(0, 0, 0, 0, 0, 0, 24'h00_0001);
      push_random(80);

      configure(1'b1, 32'h0004_0000, 0, 0, 0, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
      push_particle(32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 32'h1234_5678,
                    32'h8000_0000, 32'h7fff_ffff, 24'h01_0000);
      push_particle(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 24'hff_ffff);
      push_particle(32'h0001_0001, 32'hffff_0000, 32'h0000_8000, 0, 0, 0, 24'h01_0000);
      push_particle(32'h7fff_fff0, 32'h7fff_fff0, 32'h7fff_fff0, 32'h7fff_fff0, 0, 0,
                    24'h01_0000);
      push_random(100);

      configure(1'b1, 32'h8000_0000, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      push_particle(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 32'h8000_0000, 24'hff_ffff);
      push_particle(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 5, 5, 5, 24'hff_ffff);
      push_random(100);

      throttle = 1'b0;
      configure(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 0, 0, 0);
      push_random(100);
      throttle = 1'b1;

      for (int ph = 0; ph < 4; ph++) begin
         configure(ph[0], pick_word(), pick_word(), pick_word(), pick_word(),
                   pick_word(), pick_word(), pick_word());
         push_random(100);
      end

      configure(1'b1, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
      push_random(80);

      do @(posedge clock);
      while (pending.size() != 0 || req_valid || expected_vel.size() != 0);
      repeat (80) @(posedge clock);
      if (errors == 0) begin
         $display("particle_force_velocity_update verification clean");
      end else begin
         $display("particle_force_velocity_update verification failed");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("particle_force_velocity_update verification failed");
      $finish;
   end
endmodule
